// File: rtl/bthd_pkg.sv
package bthd_pkg;

    localparam int MAX_LENGTH_OCTETS = 5;
    localparam int POSITION_BITS     = 32;
    localparam int ACC_BITS          = 40;
    localparam int OCT_BITS          = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int OUT_POS_BITS      = 32;

    localparam logic [7:0]  INDEF_BYTE = 8'h80;
    localparam logic [7:0]  LONG_FLAG  = 8'h80;
    localparam logic [7:0]  COUNT_MASK = 8'h7F;
    localparam logic [23:0] LEN_LIMIT  = 24'hFFFFFF;

    typedef enum logic [2:0] {
        PH_TAG = 3'b001,
        PH_LEN = 3'b010,
        PH_OCT = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

endpackage

// File: rtl/ber_tlv_header_decoder.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------------
// byte     | in        | byte_valid / byte_stall | data_byte, header_byte, restart
// hdr      | out       | hdr_valid / hdr_stall   | tag_value, content_length, indefinite,
//          |           |                         | tag_position, content_position, status
//
// One byte is accepted every cycle while byte_stall is low; each byte passes an input
// register and a result register, and a header is loaded into the result register from its last byte.
// The rate is set by the single shift and compare on the length accumulator.
// Reset clears the parser state and the valid flags of both pipeline registers
// asynchronously.
// A stalled result holds the pipeline; byte_stall rises only while both stages are full.
module ber_tlv_header_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                data_byte,
    input  logic                      header_byte,
    input  logic                      restart,
    output logic                      hdr_valid,
    input  logic                      hdr_stall,
    output logic [7:0]                tag_value,
    output logic [23:0]               content_length,
    output logic                      indefinite,
    output logic [31:0]               tag_position,
    output logic [31:0]               content_position,
    output logic [1:0]                status
);

    import bthd_pkg::*;

    logic                     s1_valid_reg;
    logic [7:0]               s1_data_reg;
    logic                     s1_hdr_reg;
    logic                     s1_restart_reg;
    logic                     advance;

    phase_t                   phase_reg, phase_next, phase_eff;
    logic [7:0]               held_tag_reg, held_tag_next, held_tag_eff;
    logic [ACC_BITS-1:0]      acc_reg, acc_next, acc_eff, acc_shift;
    logic [OCT_BITS-1:0]      octets_reg, octets_next, octets_eff, octets_dec;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_eff;
    logic [POSITION_BITS-1:0] hpos_reg, hpos_next, hpos_eff;
    logic [6:0]               count;

    logic                     emit;
    logic [23:0]              len_next;
    logic                     indef_next;
    logic [POSITION_BITS-1:0] cpos_next;
    status_t                  status_next;

    logic                     out_valid_reg;
    logic [7:0]               tag_reg;
    logic [23:0]              len_reg;
    logic                     indef_reg;
    logic [OUT_POS_BITS-1:0]  tpos_reg;
    logic [OUT_POS_BITS-1:0]  cpos_reg;
    status_t                  status_reg;

    assign advance    = !out_valid_reg || !hdr_stall;
    assign byte_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            s1_data_reg    <= data_byte;
            s1_hdr_reg     <= header_byte;
            s1_restart_reg <= restart;
        end
    end

    always_comb
    begin
        if (s1_restart_reg)
        begin
            phase_eff    = PH_TAG;
            held_tag_eff = '0;
            acc_eff      = '0;
            octets_eff   = '0;
            pos_eff      = '0;
            hpos_eff     = '0;
        end
        else
        begin
            phase_eff    = phase_reg;
            held_tag_eff = held_tag_reg;
            acc_eff      = acc_reg;
            octets_eff   = octets_reg;
            pos_eff      = pos_reg;
            hpos_eff     = hpos_reg;
        end

        pos_next      = pos_eff + POSITION_BITS'(1);
        phase_next    = phase_eff;
        held_tag_next = held_tag_eff;
        acc_next      = acc_eff;
        octets_next   = octets_eff;
        hpos_next     = hpos_eff;
        count         = s1_data_reg[6:0] & COUNT_MASK[6:0];
        acc_shift     = {acc_eff[ACC_BITS-9:0], s1_data_reg};
        octets_dec    = (octets_eff != '0) ? octets_eff - OCT_BITS'(1) : octets_eff;

        emit          = 1'b0;
        len_next      = '0;
        indef_next    = 1'b0;
        cpos_next     = pos_next;
        status_next   = ST_OK;

        if (!s1_hdr_reg)
        begin
            phase_next  = PH_TAG;
            octets_next = '0;
        end
        else
        begin
            case (phase_eff)
                PH_LEN:
                begin
                    if (s1_data_reg == INDEF_BYTE)
                    begin
                        emit       = 1'b1;
                        indef_next = 1'b1;
                        phase_next = PH_TAG;
                    end
                    else if ((s1_data_reg & LONG_FLAG) == 8'h00)
                    begin
                        emit       = 1'b1;
                        len_next   = {16'h0000, s1_data_reg};
                        phase_next = PH_TAG;
                    end
                    else if (count > 7'(MAX_LENGTH_OCTETS))
                    begin
                        emit        = 1'b1;
                        cpos_next   = '0;
                        status_next = ST_COUNT;
                        phase_next  = PH_TAG;
                    end
                    else
                    begin
                        acc_next    = '0;
                        octets_next = count[OCT_BITS-1:0];
                        phase_next  = PH_OCT;
                    end
                end
                PH_OCT:
                begin
                    acc_next    = acc_shift;
                    octets_next = octets_dec;
                    if (octets_dec == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_TAG;
                        if (acc_shift > ACC_BITS'(LEN_LIMIT))
                        begin
                            cpos_next   = '0;
                            status_next = ST_LIMIT;
                        end
                        else
                        begin
                            len_next = acc_shift[23:0];
                        end
                    end
                end
                default:
                begin
                    hpos_next     = pos_eff;
                    held_tag_next = s1_data_reg;
                    phase_next    = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            held_tag_reg  <= '0;
            acc_reg       <= '0;
            octets_reg    <= '0;
            pos_reg       <= '0;
            hpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && emit;
            if (s1_valid_reg)
            begin
                phase_reg    <= phase_next;
                held_tag_reg <= held_tag_next;
                acc_reg      <= acc_next;
                octets_reg   <= octets_next;
                pos_reg      <= pos_next;
                hpos_reg     <= hpos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && emit)
        begin
            tag_reg    <= held_tag_eff;
            len_reg    <= len_next;
            indef_reg  <= indef_next;
            tpos_reg   <= OUT_POS_BITS'(hpos_eff);
            cpos_reg   <= OUT_POS_BITS'(cpos_next);
            status_reg <= status_next;
        end
    end

    assign hdr_valid        = out_valid_reg;
    assign tag_value        = tag_reg;
    assign content_length   = len_reg;
    assign indefinite       = indef_reg;
    assign tag_position     = tpos_reg;
    assign content_position = cpos_reg;
    assign status           = status_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (hdr_valid && hdr_stall))
        else $error("input stalled while the result side could move");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid && status != ST_OK) |->
            (content_length == 24'h0 && content_position == 32'h0 && !indefinite))
        else $error("failed header carries a length or position");

    a_indef_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid && indefinite) |-> (content_length == 24'h0 && status == ST_OK))
        else $error("indefinite header with a length or an error");

    a_octets_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_OCT) |->
            (octets_reg != '0 && octets_reg <= OCT_BITS'(MAX_LENGTH_OCTETS)))
        else $error("length octet count out of range");

endmodule
